/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the continuation detector checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Overlapping implication, sampled on the rising clock edge, off during reset.
`define RCD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define RCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hw/rtl/rcd_pkg.sv */
// ----------------------------------------------------------------------------
// rcd_pkg
// Types, character codes and keyword tables of the continuation detector.
// ----------------------------------------------------------------------------
package rcd_pkg;

  localparam int DEPTH_WIDTH_DEF = 16;
  localparam int POS_W           = 3;
  localparam int KW_COUNT        = 8;
  localparam int CAND_W          = KW_COUNT + 1;
  localparam int CAND_AT         = KW_COUNT;
  localparam int KW_ASYNC        = 7;
  localparam int SKIP_W          = 2;
  localparam int ADDR_W          = 3;
  localparam int DATA_W          = 32;

  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_NUL    = 8'h00;

  // Register index of the async enable bit.
  localparam logic [0:0] REG_ASYNC_EN = 1'b0;

  typedef enum logic [2:0] {
    QM_NONE = 3'd0,
    QM_SQ1  = 3'd1,
    QM_DQ1  = 3'd2,
    QM_SQ3  = 3'd3,
    QM_DQ3  = 3'd4
  } quote_mode_t;

  typedef enum logic [2:0] {
    RSN_DONE      = 3'd0,
    RSN_TRIPLE    = 3'd1,
    RSN_BRACKET   = 3'd2,
    RSN_BACKSLASH = 3'd3,
    RSN_KEYWORD   = 3'd4
  } reason_t;

  typedef struct packed {
    logic advance;
    logic clear;
  } kw_ctrl_t;

  typedef struct packed {
    logic hit;
    logic at_start;
  } kw_stat_t;

  function automatic logic [POS_W-1:0] kw_len(input logic [2:0] k);
    logic [POS_W-1:0] len;
    case (k)
      3'd0:    len = 3'd2;
      3'd1:    len = 3'd5;
      3'd2:    len = 3'd3;
      3'd3:    len = 3'd3;
      3'd4:    len = 3'd4;
      3'd5:    len = 3'd3;
      3'd6:    len = 3'd5;
      default: len = 3'd5;
    endcase
    return len;
  endfunction

  // Byte p of keyword k, counted from the first letter.
  function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [POS_W-1:0] p);
    logic [39:0] txt;
    logic [7:0]  ch;
    case (k)
      3'd0:    txt = {"if", 24'h0};
      3'd1:    txt = "while";
      3'd2:    txt = {"for", 16'h0};
      3'd3:    txt = {"try", 16'h0};
      3'd4:    txt = {"with", 8'h0};
      3'd5:    txt = {"def", 16'h0};
      3'd6:    txt = "class";
      default: txt = "async";
    endcase
    case (p)
      3'd0:    ch = txt[39:32];
      3'd1:    ch = txt[31:24];
      3'd2:    ch = txt[23:16];
      3'd3:    ch = txt[15:8];
      3'd4:    ch = txt[7:0];
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

  function automatic logic is_ident(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A) || c == 8'h5F;
  endfunction

endpackage

/* hw/rtl/repl_continuation_detector.sv */
// Flow: an accepted item is held in the input register; a final item's result is then
// registered in the output register and shows on the outputs until it is taken.
// Throughput: one item per cycle; the state update is one pass of shallow
// logic from the input register. Only a result that waits unaccepted stalls.
// Reset (synchronous, rst_n low) clears the scan state and the async enable.
// ----------------------------------------------------------------------------
// repl_continuation_detector
// Decides per entered text whether an interactive prompt needs another line.
// ----------------------------------------------------------------------------
module repl_continuation_detector #(
  parameter int DEPTH_WIDTH = rcd_pkg::DEPTH_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 in_current_char,
  input  logic [7:0]                 in_next_char,
  input  logic [7:0]                 in_next_next_char,
  input  logic                       in_last_char_flag,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_need_more,
  output logic [2:0]                 out_reason_code,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rcd_pkg::ADDR_W-1:0] paddr,
  input  logic [rcd_pkg::DATA_W-1:0] pwdata,
  output logic [rcd_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam logic signed [DEPTH_WIDTH-1:0] D_MAX = {1'b0, {(DEPTH_WIDTH-1){1'b1}}};
  localparam logic signed [DEPTH_WIDTH-1:0] D_MIN = {1'b1, {(DEPTH_WIDTH-1){1'b0}}};

  function automatic logic signed [DEPTH_WIDTH-1:0] sat_inc(
      input logic signed [DEPTH_WIDTH-1:0] v);
    return (v == D_MAX) ? v : v + 1'b1;
  endfunction

  function automatic logic signed [DEPTH_WIDTH-1:0] sat_dec(
      input logic signed [DEPTH_WIDTH-1:0] v);
    return (v == D_MIN) ? v : v - 1'b1;
  endfunction

  function automatic logic is_open(input logic signed [DEPTH_WIDTH-1:0] v);
    return !v[DEPTH_WIDTH-1] && (v != '0);
  endfunction

  // Configuration
  logic async_en_r;

  assign pready = 1'b1;
  assign prdata = {{(rcd_pkg::DATA_W-1){1'b0}}, async_en_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      async_en_r <= 1'b0;
    end else if (psel && penable && pwrite &&
                 paddr[rcd_pkg::ADDR_W-1:2] == rcd_pkg::REG_ASYNC_EN) begin
      async_en_r <= pwdata[0];
    end
  end

  // Input register
  logic       s1_valid_r;
  logic [7:0] s1_cur_r, s1_n1_r, s1_n2_r;
  logic       s1_last_r;
  logic       slot_free, s1_go;

  assign slot_free = !out_valid || out_ready;
  assign s1_go     = s1_valid_r && (!s1_last_r || slot_free);
  assign in_ready  = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_cur_r  <= in_current_char;
      s1_n1_r   <= in_next_char;
      s1_n2_r   <= in_next_next_char;
      s1_last_r <= in_last_char_flag;
    end
  end

  // Keyword matcher
  rcd_pkg::kw_ctrl_t kw_ctrl;
  rcd_pkg::kw_stat_t kw_stat;

  assign kw_ctrl.advance = s1_go;
  assign kw_ctrl.clear   = s1_last_r;

  rcd_kw_match u_kw (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (kw_ctrl),
    .cur_char (s1_cur_r),
    .async_en (async_en_r),
    .stat     (kw_stat)
  );

  // Quote and bracket scan
  rcd_pkg::quote_mode_t              qm_r, qm_nxt;
  logic [rcd_pkg::SKIP_W-1:0]        skip_r, skip_nxt;
  logic signed [DEPTH_WIDTH-1:0]     paren_r, paren_nxt;
  logic signed [DEPTH_WIDTH-1:0]     brack_r, brack_nxt;
  logic signed [DEPTH_WIDTH-1:0]     brace_r, brace_nxt;

  always_comb begin
    qm_nxt    = qm_r;
    skip_nxt  = skip_r;
    paren_nxt = paren_r;
    brack_nxt = brack_r;
    brace_nxt = brace_r;
    if (skip_r != '0) begin
      skip_nxt = skip_r - 1'b1;
    end else if (s1_cur_r == rcd_pkg::CH_SQUOTE) begin
      if ((qm_r == rcd_pkg::QM_NONE || qm_r == rcd_pkg::QM_SQ3) &&
          s1_n1_r == rcd_pkg::CH_SQUOTE && s1_n2_r == rcd_pkg::CH_SQUOTE) begin
        skip_nxt = 2'd2;
        qm_nxt   = (qm_r == rcd_pkg::QM_NONE) ? rcd_pkg::QM_SQ3 : rcd_pkg::QM_NONE;
      end else if (qm_r == rcd_pkg::QM_NONE) begin
        qm_nxt = rcd_pkg::QM_SQ1;
      end else if (qm_r == rcd_pkg::QM_SQ1) begin
        qm_nxt = rcd_pkg::QM_NONE;
      end
    end else if (s1_cur_r == rcd_pkg::CH_DQUOTE) begin
      if ((qm_r == rcd_pkg::QM_NONE || qm_r == rcd_pkg::QM_DQ3) &&
          s1_n1_r == rcd_pkg::CH_DQUOTE && s1_n2_r == rcd_pkg::CH_DQUOTE) begin
        skip_nxt = 2'd2;
        qm_nxt   = (qm_r == rcd_pkg::QM_NONE) ? rcd_pkg::QM_DQ3 : rcd_pkg::QM_NONE;
      end else if (qm_r == rcd_pkg::QM_NONE) begin
        qm_nxt = rcd_pkg::QM_DQ1;
      end else if (qm_r == rcd_pkg::QM_DQ1) begin
        qm_nxt = rcd_pkg::QM_NONE;
      end
    end else if (s1_cur_r == rcd_pkg::CH_BSLASH &&
                 (s1_n1_r == rcd_pkg::CH_SQUOTE || s1_n1_r == rcd_pkg::CH_DQUOTE ||
                  s1_n1_r == rcd_pkg::CH_BSLASH)) begin
      // An escape only hides the next byte inside a string.
      if (qm_r != rcd_pkg::QM_NONE) begin
        skip_nxt = 2'd1;
      end
    end else if (qm_r == rcd_pkg::QM_NONE) begin
      case (s1_cur_r)
        rcd_pkg::CH_LPAREN: paren_nxt = sat_inc(paren_r);
        rcd_pkg::CH_RPAREN: paren_nxt = sat_dec(paren_r);
        rcd_pkg::CH_LBRACK: brack_nxt = sat_inc(brack_r);
        rcd_pkg::CH_RBRACK: brack_nxt = sat_dec(brack_r);
        rcd_pkg::CH_LBRACE: brace_nxt = sat_inc(brace_r);
        rcd_pkg::CH_RBRACE: brace_nxt = sat_dec(brace_r);
        default: ;
      endcase
    end
  end

  // Decision for a final item
  logic             empty_text;
  rcd_pkg::reason_t reason;

  assign empty_text = kw_stat.at_start && s1_cur_r == rcd_pkg::CH_NUL;

  always_comb begin
    if (empty_text) begin
      reason = rcd_pkg::RSN_DONE;
    end else if (qm_nxt == rcd_pkg::QM_SQ3 || qm_nxt == rcd_pkg::QM_DQ3) begin
      reason = rcd_pkg::RSN_TRIPLE;
    end else if ((is_open(paren_nxt) || is_open(brack_nxt) || is_open(brace_nxt)) &&
                 qm_nxt == rcd_pkg::QM_NONE) begin
      reason = rcd_pkg::RSN_BRACKET;
    end else if (s1_cur_r == rcd_pkg::CH_BSLASH) begin
      reason = rcd_pkg::RSN_BACKSLASH;
    end else if (kw_stat.hit && s1_cur_r != rcd_pkg::CH_NL) begin
      reason = rcd_pkg::RSN_KEYWORD;
    end else begin
      reason = rcd_pkg::RSN_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (s1_go && s1_last_r)) begin
      qm_r    <= rcd_pkg::QM_NONE;
      skip_r  <= '0;
      paren_r <= '0;
      brack_r <= '0;
      brace_r <= '0;
    end else if (s1_go) begin
      qm_r    <= qm_nxt;
      skip_r  <= skip_nxt;
      paren_r <= paren_nxt;
      brack_r <= brack_nxt;
      brace_r <= brace_nxt;
    end
  end

  // Output register
  logic       out_valid_r;
  logic       out_need_r;
  logic [2:0] out_reason_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last_r) begin
      out_need_r   <= (reason != rcd_pkg::RSN_DONE);
      out_reason_r <= reason;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_need_more   = out_need_r;
  assign out_reason_code = out_reason_r;

endmodule

/* hw/rtl/rcd_kw_match.sv */
// ----------------------------------------------------------------------------
// rcd_kw_match
// Matches the start of the text against the compound keywords and a leading
// at sign, one byte per item.
// ----------------------------------------------------------------------------
module rcd_kw_match (
  input  logic              clk,
  input  logic              rst_n,
  input  rcd_pkg::kw_ctrl_t ctrl,
  input  logic [7:0]        cur_char,
  input  logic              async_en,
  output rcd_pkg::kw_stat_t stat
);

  logic [rcd_pkg::POS_W-1:0]  pos_r, pos_nxt;
  logic [rcd_pkg::CAND_W-1:0] cand_r, cand_nxt;
  logic                       found_r, found_nxt;
  logic                       hit;

  always_comb begin
    cand_nxt  = cand_r;
    found_nxt = found_r;
    for (int k = 0; k < rcd_pkg::KW_COUNT; k++) begin
      if (cand_r[k]) begin
        if (pos_r < rcd_pkg::kw_len(3'(k))) begin
          if (cur_char != rcd_pkg::kw_char(3'(k), pos_r)) begin
            cand_nxt[k] = 1'b0;
          end
        end else begin
          if (pos_r == rcd_pkg::kw_len(3'(k)) && !rcd_pkg::is_ident(cur_char) &&
              (k != rcd_pkg::KW_ASYNC || async_en)) begin
            found_nxt = 1'b1;
          end
          cand_nxt[k] = 1'b0;
        end
      end
    end
    if (cand_r[rcd_pkg::CAND_AT]) begin
      if (pos_r == '0 && cur_char == rcd_pkg::CH_AT) begin
        found_nxt = 1'b1;
      end
      cand_nxt[rcd_pkg::CAND_AT] = 1'b0;
    end
    pos_nxt = (pos_r != rcd_pkg::POS_MAX) ? pos_r + 1'b1 : pos_r;

    // A keyword that ends exactly at the end of the text also counts.
    hit = found_nxt;
    for (int k = 0; k < rcd_pkg::KW_COUNT; k++) begin
      if (cand_nxt[k] && rcd_pkg::kw_len(3'(k)) == pos_nxt &&
          (k != rcd_pkg::KW_ASYNC || async_en)) begin
        hit = 1'b1;
      end
    end
  end

  assign stat.hit      = hit;
  assign stat.at_start = (pos_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n || (ctrl.advance && ctrl.clear)) begin
      pos_r   <= '0;
      cand_r  <= '1;
      found_r <= 1'b0;
    end else if (ctrl.advance) begin
      pos_r   <= pos_nxt;
      cand_r  <= cand_nxt;
      found_r <= found_nxt;
    end
  end

endmodule

/* hw/rtl/rcd_checker.sv */
// ----------------------------------------------------------------------------
// rcd_checker
// Port-level checks of the continuation detector, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rcd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_need_more,
  input logic [2:0] out_reason_code
);

  // A held result keeps its value until it is taken.
  `RCD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_need_more) && $stable(out_reason_code))

  // The decision bit is set exactly when a reason is given.
  `RCD_ASSERT_IMP(a_need_reason, clk, rst_n, out_valid, out_need_more == (out_reason_code != rcd_pkg::RSN_DONE))

  `RCD_ASSERT_IMP(a_reason_range, clk, rst_n, out_valid, out_reason_code <= rcd_pkg::RSN_KEYWORD)

  // The input side only stalls behind a result that is not being taken.
  `RCD_ASSERT_IMP(a_stall_cause, clk, rst_n, !in_ready, out_valid && !out_ready)

endmodule

bind repl_continuation_detector rcd_checker u_rcd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_need_more   (out_need_more),
  .out_reason_code (out_reason_code)
);
